// ===== rtl/multi_shape_lfo_assert.svh =====
// Assertion macros used by the oscillator top level.
`ifndef MULTI_SHAPE_LFO_ASSERT_SVH
`define MULTI_SHAPE_LFO_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("multi_shape_lfo: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("multi_shape_lfo: next-cycle check failed");

`endif

// ===== rtl/msl_pkg.sv =====
// Types, constants and the sine quarter table of the oscillator.
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QTR_DEPTH   = SINE_TABLE_DEPTH / 4;
   localparam int SINE_QTR_BITS    = SINE_ADDR_BITS - 2;
   localparam int SINE_VAL_BITS    = 15;

   localparam int PHASE_BITS = 32;
   localparam int STEP_BITS  = 31;
   localparam int SUM_BITS   = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;
   localparam int F_BITS     = 32;
   localparam int Q15_BITS   = 16;
   localparam int DIFF_BITS  = Q15_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + F_BITS + 1;
   localparam int SHAPE_BITS = 3;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = STEP_BITS;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [Q15_BITS-1:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [Q15_BITS-1:0] Q15_MIN = 16'sh8000;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd1;

   typedef enum logic [SHAPE_BITS-1:0] {
      WAVE_SINE   = 3'd0,
      WAVE_TRI    = 3'd1,
      WAVE_SAW    = 3'd2,
      WAVE_SQUARE = 3'd3,
      WAVE_HOLD   = 3'd4,
      WAVE_SMOOTH = 3'd5
   } wave_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP = 1'b0,
      CSR_WAVE_SHAPE = 1'b1
   } csr_type;

   // One tick as handed from the phase front to the shaping back end.
   typedef struct packed {
      logic [F_BITS-1:0]          phase_f;
      logic                       wrap;
      wave_type                   shape;
      logic signed [Q15_BITS-1:0] held;
      logic signed [Q15_BITS-1:0] start;
   } msl_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } msl_qstat_type;

   // Taylor series of the sine, built at elaboration in integer arithmetic.
   localparam int TAYLOR_TERMS = 12;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   function automatic logic [SINE_VAL_BITS-1:0] sine_q15(input int unsigned k);
      logic [63:0]        u;
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        q;
      u    = 64'(k) << (32 - SINE_ADDR_BITS);
      x    = (u * TWO_PI_Q30) >> 32;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / TAYLOR_DIV[n-1];
         if (n[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      q = (64'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[SINE_VAL_BITS-1:0];
   endfunction

   function automatic logic [SINE_QTR_DEPTH*SINE_VAL_BITS-1:0] build_sine_qtr();
      logic [SINE_QTR_DEPTH*SINE_VAL_BITS-1:0] tab;
      tab = '0;
      for (int k = 0; k < SINE_QTR_DEPTH; k++) begin
         tab[k*SINE_VAL_BITS +: SINE_VAL_BITS] = sine_q15(k);
      end
      return tab;
   endfunction

   localparam logic [SINE_QTR_DEPTH*SINE_VAL_BITS-1:0] SINE_QTR_TABLE = build_sine_qtr();

   function automatic logic [SINE_VAL_BITS-1:0] sine_qtr(input logic [SINE_QTR_BITS-1:0] j);
      return SINE_QTR_TABLE[int'(j)*SINE_VAL_BITS +: SINE_VAL_BITS];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/msl_front.sv =====
// Phase front: registers, phase accumulator and noise state per accepted tick.
`timescale 1ns / 1ps
`default_nettype none

module msl_front import msl_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic signed [Q15_BITS-1:0]  random_sample,
   input  wire logic                        csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_wdata,
   output msl_item_type                     item
);

   logic [STEP_BITS-1:0]        step_ff, step_in;
   wave_type                    shape_ff, shape_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic signed [Q15_BITS-1:0]  held_ff, held_in;
   logic signed [Q15_BITS-1:0]  start_ff, start_in;

   logic [SUM_BITS-1:0]         sum;
   logic                        wrap;
   logic [PHASE_BITS-1:0]       phase_new;
   logic [PHASE_BITS+F_BITS-1:0] phase_ext;

   // Configuration decode.
   always_comb begin
      step_in  = step_ff;
      shape_in = shape_ff;
      if (csr_write_en) begin
         unique case (csr_type'(csr_index))
            CSR_PHASE_STEP: step_in  = csr_wdata[STEP_BITS-1:0];
            CSR_WAVE_SHAPE: shape_in = wave_type'(csr_wdata[SHAPE_BITS-1:0]);
         endcase
      end
   end

   // Phase recurrence: carry out of the accumulator marks a wrap.
   always_comb begin
      sum       = SUM_BITS'(phase_ff) + SUM_BITS'(step_ff);
      wrap      = |sum[SUM_BITS-1:PHASE_BITS];
      phase_new = sum[PHASE_BITS-1:0];
      phase_ext = {phase_new, {F_BITS{1'b0}}};
      phase_in  = accept ? phase_new : phase_ff;
   end

   // Noise state moves only on a wrap, and only for the noise shapes.
   always_comb begin
      held_in  = held_ff;
      start_in = start_ff;
      if (accept && wrap) begin
         case (shape_ff)
            WAVE_HOLD: held_in = random_sample;
            WAVE_SMOOTH: begin
               start_in = held_ff;
               held_in  = random_sample;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      item.phase_f = phase_ext[PHASE_BITS+F_BITS-1 -: F_BITS];
      item.wrap    = wrap;
      item.shape   = shape_ff;
      item.held    = held_in;
      item.start   = start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_RESET;
         shape_ff <= WAVE_SINE;
         phase_ff <= '0;
         held_ff  <= '0;
         start_ff <= '0;
      end else begin
         step_ff  <= step_in;
         shape_ff <= shape_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msl_queue.sv =====
// Short queue of classified ticks between the phase front and the back end.
`timescale 1ns / 1ps
`default_nettype none

module msl_queue import msl_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire msl_item_type push_item,
   input  wire logic   pop,
   output msl_item_type pop_item,
   output msl_qstat_type status
);

   msl_item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msl_back.sv =====
// Shaping back end: wave generation, noise interpolation and result register.
`timescale 1ns / 1ps
`default_nettype none

module msl_back import msl_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire msl_item_type                item,
   input  wire logic                        q_empty,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [Q15_BITS-1:0]       rsp_lfo_value,
   output logic                             rsp_cycle_wrapped
);

   logic                        s1_valid_ff, s1_valid_in;
   logic signed [Q15_BITS-1:0]  s1_value_ff, s1_value_in;
   logic signed [PROD_BITS-1:0] s1_prod_ff, s1_prod_in;
   logic signed [Q15_BITS-1:0]  s1_start_ff;
   logic                        s1_smooth_ff, s1_smooth_in;
   logic                        s1_wrap_ff;

   logic                        out_valid_ff, out_valid_in;
   logic signed [Q15_BITS-1:0]  out_lfo_ff, out_lfo_in;
   logic                        out_wrap_ff;

   logic                        out_free, s1_free;

   logic [SINE_ADDR_BITS-1:0]   sin_idx;
   logic [1:0]                  sin_quad;
   logic [SINE_QTR_BITS-1:0]    sin_j;
   logic [SINE_QTR_BITS-1:0]    sin_j_mirror;
   logic signed [Q15_BITS-1:0]  sin_mag;
   logic signed [Q15_BITS-1:0]  sin_val;
   logic [F_BITS-15-1:0]        tri_top;
   logic signed [Q15_BITS+1:0]  tri_raw;
   logic signed [Q15_BITS-1:0]  tri_val;
   logic signed [DIFF_BITS-1:0] diff;

   // Advance each stage when the one behind it is empty or draining.
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign s1_free     = !s1_valid_ff || out_free;
   assign pop         = !q_empty && s1_free;
   assign s1_valid_in = s1_free ? pop : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   // Sine from a quarter table, folded by quadrant.
   always_comb begin
      sin_idx      = item.phase_f[F_BITS-1 -: SINE_ADDR_BITS];
      sin_quad     = sin_idx[SINE_ADDR_BITS-1 -: 2];
      sin_j        = sin_idx[SINE_QTR_BITS-1:0];
      sin_j_mirror = SINE_QTR_BITS'(0) - sin_j;
      if (!sin_quad[0]) begin
         sin_mag = $signed({1'b0, sine_qtr(sin_j)});
      end else if (sin_j == '0) begin
         sin_mag = Q15_MAX;
      end else begin
         sin_mag = $signed({1'b0, sine_qtr(sin_j_mirror)});
      end
      sin_val = sin_quad[1] ? -sin_mag : sin_mag;
   end

   // Triangle: rise, fall, rise again; the positive peak saturates.
   always_comb begin
      tri_top = item.phase_f[F_BITS-1:15];
      case (item.phase_f[F_BITS-1 -: 2])
         2'b00:   tri_raw = $signed({1'b0, tri_top});
         2'b11:   tri_raw = $signed({1'b0, tri_top}) - 18'sd131072;
         default: tri_raw = 18'sd65536 - $signed({1'b0, tri_top});
      endcase
      tri_val = (tri_raw > 18'sd32767) ? Q15_MAX : tri_raw[Q15_BITS-1:0];
   end

   always_comb begin
      diff       = DIFF_BITS'(item.held) - DIFF_BITS'(item.start);
      s1_prod_in = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, item.phase_f}));
   end

   always_comb begin
      s1_smooth_in = 1'b0;
      unique case (item.shape)
         WAVE_SINE:   s1_value_in = sin_val;
         WAVE_TRI:    s1_value_in = tri_val;
         WAVE_SAW:    s1_value_in = $signed({~item.phase_f[F_BITS-1],
                                             item.phase_f[F_BITS-2 -: Q15_BITS-1]});
         WAVE_SQUARE: s1_value_in = item.phase_f[F_BITS-1] ? Q15_MIN : Q15_MAX;
         WAVE_HOLD:   s1_value_in = item.held;
         WAVE_SMOOTH: begin
            s1_value_in  = item.start;
            s1_smooth_in = 1'b1;
         end
         default:     s1_value_in = '0;
      endcase
   end

   // Floor of the product over 2^32 is its arithmetic shift.
   assign out_lfo_in = s1_smooth_ff ? s1_start_ff + s1_prod_ff[F_BITS +: Q15_BITS]
                                    : s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_value_ff  <= s1_value_in;
         s1_prod_ff   <= s1_prod_in;
         s1_start_ff  <= item.start;
         s1_smooth_ff <= s1_smooth_in;
         s1_wrap_ff   <= item.wrap;
      end
      if (out_free && s1_valid_ff) begin
         out_lfo_ff  <= out_lfo_in;
         out_wrap_ff <= s1_wrap_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lfo_value     = out_lfo_ff;
   assign rsp_cycle_wrapped = out_wrap_ff;

endmodule

`default_nettype wire

// ===== rtl/multi_shape_lfo.sv =====
// Multi-shape low-frequency oscillator, top level.
// An accepted tick passes the queue, stage one and the output register to rsp.
// Throughput: one tick per clock while req_stall is low.
// A two-beat queue parts the phase front from the shaping pipeline.
// Reset (synchronous, high) clears phase, noise state and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_shape_lfo_assert.svh"

module multi_shape_lfo import msl_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // tick input channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [Q15_BITS-1:0]  req_random_sample,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [Q15_BITS-1:0]       rsp_lfo_value,
   output logic                             rsp_cycle_wrapped,
   // register writes
   input  wire logic                        csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   msl_item_type  front_item;
   msl_item_type  back_item;
   msl_qstat_type q_status;
   logic          accept;
   logic          q_pop;

   // Stall the tick channel only while the queue holds two beats.
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Front: advance the phase and update the noise state as each beat lands.
   msl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .random_sample (req_random_sample),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .item          (front_item)
   );

   // Queue: hold classified beats so either side may stall on its own.
   msl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (back_item),
      .status    (q_status)
   );

   // Back end: form the wave, interpolate smoothed noise, register the result.
   msl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item              (back_item),
      .q_empty           (q_status.empty),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lfo_value     (rsp_lfo_value),
      .rsp_cycle_wrapped (rsp_cycle_wrapped)
   );

   // Never drain a beat the queue does not hold.
   `MSL_ASSERT_NOW(a_pop_needs_beat, clock, reset, q_pop, !q_status.empty)
   // A lone push into an empty queue leaves a beat behind.
   `MSL_ASSERT_NEXT(a_push_lands, clock, reset, accept && q_status.empty && !q_pop, !q_status.empty)
   // A lone pop from a full queue releases the tick channel.
   `MSL_ASSERT_NEXT(a_pop_frees, clock, reset, q_status.full && q_pop && !accept, !req_stall)

endmodule

`default_nettype wire

// ===== tb/multi_shape_lfo_checker.sv =====
// Scoreboard for the oscillator: predicts each tick and checks the result beats.
`timescale 1ns / 1ps

module multi_shape_lfo_checker import msl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [Q15_BITS-1:0] req_random_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [Q15_BITS-1:0] rsp_lfo_value,
   input  logic                       rsp_cycle_wrapped,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic signed [Q15_BITS-1:0] level;
      logic                       wrapped;
   } lfo_beat_type;

   localparam logic [63:0] ANGLE_TWO_PI_Q30 = 64'd6746518852;

   logic signed [Q15_BITS-1:0] sine_lut [SINE_TABLE_DEPTH];
   logic [PHASE_BITS-1:0]      phase;
   logic [STEP_BITS-1:0]       step_cfg;
   logic [SHAPE_BITS-1:0]      shape_cfg;
   logic signed [Q15_BITS-1:0] held_level;
   logic signed [Q15_BITS-1:0] start_level;
   lfo_beat_type               beats_due [$];

   // Sine of 2*pi*k/depth in Q15 by a Taylor series, folded into the first quadrant.
   function automatic logic signed [Q15_BITS-1:0] sine_at(input int unsigned k);
      logic [63:0] ang;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] mag;
      longint      acc;
      bit          neg;
      ang = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
      neg = 1'b0;
      if (ang >= 64'h8000_0000) begin
         neg = 1'b1;
         ang = ang - 64'h8000_0000;
      end
      if (ang > 64'h4000_0000) begin
         ang = 64'h8000_0000 - ang;
      end
      x    = (ang * ANGLE_TWO_PI_Q30) >> 32;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      mag = (64'(acc) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return neg ? -16'(mag) : 16'(mag);
   endfunction

   // Advance the phase by one tick and form the output of the selected shape.
   function automatic lfo_beat_type advance_oscillator(input logic signed [Q15_BITS-1:0] noise);
      logic [PHASE_BITS:0] sum;
      logic [31:0]         f;
      int                  v;
      int                  idx;
      longint              span;
      longint              prod;
      lfo_beat_type        beat;
      sum          = {1'b0, phase} + {2'b00, step_cfg};
      beat.wrapped = sum[PHASE_BITS];
      phase        = sum[PHASE_BITS-1:0];
      f            = phase;
      v            = 0;
      case (shape_cfg)
         WAVE_SINE: begin
            idx = int'((64'(f) * 64'(SINE_TABLE_DEPTH)) >> 32);
            v   = sine_lut[idx];
         end
         WAVE_TRI: begin
            if (f < 32'h4000_0000) begin
               v = int'(f >> 15);
            end else if (f < 32'hC000_0000) begin
               v = 65536 - int'(f >> 15);
            end else begin
               v = int'(f >> 15) - 131072;
            end
            if (v > 32767) begin
               v = 32767;
            end
         end
         WAVE_SAW: begin
            v = int'(f >> 16) - 32768;
         end
         WAVE_SQUARE: begin
            v = f[31] ? -32768 : 32767;
         end
         WAVE_HOLD: begin
            if (beat.wrapped) begin
               held_level = noise;
            end
            v = held_level;
         end
         WAVE_SMOOTH: begin
            if (beat.wrapped) begin
               start_level = held_level;
               held_level  = noise;
            end
            span = longint'(held_level) - longint'(start_level);
            prod = span * $signed({32'd0, f});
            v    = start_level + int'(prod >>> 32);
         end
         default: begin
            v = 0;
         end
      endcase
      beat.level = v[Q15_BITS-1:0];
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] %s mismatch: got 0x%h, expected 0x%h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         sine_lut[k] = sine_at(k);
      end
   end

   always @(posedge clock) begin : watch_channels
      lfo_beat_type want;
      if (reset) begin
         phase       = '0;
         step_cfg    = STEP_RESET;
         shape_cfg   = WAVE_SINE;
         held_level  = '0;
         start_level = '0;
         beats_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PHASE_STEP: step_cfg  = csr_wdata[STEP_BITS-1:0];
               CSR_WAVE_SHAPE: shape_cfg = csr_wdata[SHAPE_BITS-1:0];
               default: ;
            endcase
         end
         // drain before fill: a beat can never leave in the cycle it arrives
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               report_mismatch("beat with nothing due", rsp_lfo_value, 'x);
            end else begin
               want = beats_due.pop_front();
               if (rsp_lfo_value !== want.level) begin
                  report_mismatch("lfo_value", rsp_lfo_value, want.level);
               end
               if (rsp_cycle_wrapped !== want.wrapped) begin
                  report_mismatch("cycle_wrapped", 16'(rsp_cycle_wrapped), 16'(want.wrapped));
               end
            end
         end
         if (req_valid && !req_stall) begin
            beats_due.push_back(advance_oscillator(req_random_sample));
         end
      end
      pending_count = beats_due.size();
   end

endmodule

// ===== tb/multi_shape_lfo_tb.sv =====
// Top of the oscillator testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module multi_shape_lfo_tb import msl_pkg::*;;

   // shape codes the block leaves undefined: output zero, noise state untouched
   localparam logic [SHAPE_BITS-1:0] SHAPE_RESERVED_LO = 3'd6;
   localparam logic [SHAPE_BITS-1:0] SHAPE_RESERVED_HI = 3'd7;
   localparam logic [STEP_BITS-1:0]  STEP_FULL         = 31'h7FFF_FFFF;
   localparam int                    RANDOM_TICKS      = 500;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [Q15_BITS-1:0]  req_random_sample;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [Q15_BITS-1:0]  rsp_lfo_value;
   logic                        rsp_cycle_wrapped;
   logic                        csr_write_en;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;
   int                          fail_count;
   int                          pending_count;

   // knobs shared by the stimulus and the receiver process
   bit sender_idles    = 1'b1;
   bit receiver_idles  = 1'b1;
   int hold_off_cycles = 0;

   multi_shape_lfo u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_random_sample (req_random_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lfo_value     (rsp_lfo_value),
      .rsp_cycle_wrapped (rsp_cycle_wrapped),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   multi_shape_lfo_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_random_sample (req_random_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lfo_value     (rsp_lfo_value),
      .rsp_cycle_wrapped (rsp_cycle_wrapped),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, or hold off solidly when asked. The hold-off
   // is counted down here at each falling edge, so the sender runs on freely.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(0, 99) < 11);
         end
      end
   end

   // Hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Write both registers on consecutive edges. The shape word carries random
   // upper bits, which the block must ignore.
   task automatic configure(input logic [STEP_BITS-1:0] step,
                            input logic [SHAPE_BITS-1:0] shape);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PHASE_STEP;
      csr_wdata    <= CSR_DATA_BITS'(step);
      @(negedge clock);
      csr_index    <= CSR_WAVE_SHAPE;
      csr_wdata    <= {(CSR_DATA_BITS - SHAPE_BITS)'($urandom), shape};
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Offer one beat per sample. Valid stays high from one beat to the next
   // unless an idle cycle is drawn; drop it only once the list is spent.
   task automatic play_ticks(input logic [15:0] samples [$]);
      for (int i = 0; i < samples.size(); i++) begin
         while (sender_idles && ($urandom_range(0, 99) < 11)) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid         <= 1'b1;
         req_random_sample <= samples[i];
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   // Wait until every predicted beat has come back, then let the
   // pipeline run dry before anything touches the registers.
   task automatic settle();
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic [STEP_BITS-1:0] step,
                            input logic [SHAPE_BITS-1:0] shape,
                            input logic [15:0] samples [$]);
      configure(step, shape);
      play_ticks(samples);
      settle();
   endtask

   initial begin
      logic [15:0]           samples [$];
      logic [STEP_BITS-1:0]  step;
      logic [SHAPE_BITS-1:0] shape;
      int                    fed;
      int                    phase_no;
      int                    count;
      int                    pick;

      // every input known from time zero; reset held high at the start
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_random_sample = '0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_PHASE_STEP;
      csr_wdata         = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. First a couple of ticks on the reset settings
      // (sine, step of one) to check the reset values of the registers.
      samples = '{16'h1234, 16'h0000};
      play_ticks(samples);
      settle();

      // Full step: the phase wraps about every other tick, so the held
      // value latches the extremes of the random input.
      samples = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      run_phase(STEP_FULL, WAVE_HOLD, samples);
      samples = '{16'h8000, 16'h7FFF, 16'h5A5A, 16'hA5A5};
      run_phase(STEP_FULL, WAVE_SMOOTH, samples);

      // undefined shapes: zero out, wrap still flagged, noise state frozen
      samples = '{16'h1111, 16'hEEEE};
      run_phase(31'h4000_0000, SHAPE_RESERVED_LO, samples);
      samples = '{16'h7001, 16'h8FFE};
      run_phase(31'h6000_0000, SHAPE_RESERVED_HI, samples);

      // zero step: the phase stands still and never wraps
      samples = '{16'h0F0F, 16'hF0F0};
      run_phase('0, WAVE_SMOOTH, samples);

      samples = '{16'h0001, 16'h0002, 16'h0003};
      run_phase(31'h2000_0000, WAVE_TRI, samples);
      samples = '{16'h0004, 16'h0005};
      run_phase(31'h4000_0000, WAVE_SAW, samples);
      samples = '{16'h0006, 16'h0007};
      run_phase(31'h4000_0000, WAVE_SQUARE, samples);
      samples = '{16'h0008, 16'h0009};
      run_phase(31'h0800_0000, WAVE_SINE, samples);

      // Random part: phases of random settings and random noise. Half the steps
      // lie in the range where the phase wraps every 8 to 1024 ticks, so both
      // noise shapes see fresh values; the rest are tiny, fully random, zero, one or full.
      fed      = 0;
      phase_no = 0;
      while (fed < RANDOM_TICKS) begin
         case ($urandom_range(0, 5))
            0:       step = STEP_BITS'($urandom_range(1, 1024));
            1:       step = STEP_BITS'($urandom);
            2: begin
               pick = $urandom_range(0, 2);
               step = (pick == 0) ? '0 : ((pick == 1) ? STEP_BITS'(1) : STEP_FULL);
            end
            default: step = STEP_BITS'($urandom_range(32'h0040_0000, 32'h2000_0000));
         endcase
         // weight the noise shapes, which carry the most state
         pick  = $urandom_range(0, 9);
         shape = (pick < 8) ? SHAPE_BITS'(pick) : ((pick == 8) ? WAVE_HOLD : WAVE_SMOOTH);
         count = $urandom_range(8, 48);

         sender_idles   = 1'b1;
         receiver_idles = 1'b1;
         if (phase_no == 2) begin
            // a long stretch at full rate on both sides
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
            count          = 80;
         end else if (phase_no == 4) begin
            // hold the receiver off while the sender keeps offering beats,
            // so the block fills up and stalls its input
            sender_idles    = 1'b0;
            hold_off_cycles = 60;
            count           = 64;
         end

         samples.delete();
         repeat (count) samples.push_back(16'($urandom));
         run_phase(step, shape, samples);
         fed += count;
         phase_no++;
      end

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
